// ===== hdl/bbmti_pkg.sv =====
package bbmti_pkg;

  // Fixed point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int ACC_W     = 31;
  localparam int TIME_W    = 32;
  localparam int DIFF_W    = VAL_W + 1;
  localparam int PROD_W    = 2 * VAL_W;

  // Discriminant, root and numerator widths
  localparam int S_W       = PROD_W + 2;
  localparam int ROOT_W    = 36;
  localparam int REM_W     = 2 * ROOT_W;
  localparam int NUM_W     = 37;
  localparam int DVD_W     = NUM_W + FRAC_BITS;

  // Pipeline depths of the iterative units
  localparam int SQRT_LAT  = ROOT_W;
  localparam int DIV_LAT   = TIME_W + 1;

  // Configuration port
  localparam int ADDR_W    = 3;
  localparam int APB_W     = 32;
  localparam logic [0:0] REG_ACCEL_LIMIT = 1'b0;
  localparam logic [ACC_W-1:0] ACCEL_RESET = ACC_W'(65536);

  typedef struct packed {
    logic signed [VAL_W-1:0] start_pos;
    logic signed [VAL_W-1:0] start_vel;
    logic signed [VAL_W-1:0] target_pos;
  } in_word_t;

  typedef struct packed {
    logic              plus_valid;
    logic [TIME_W-1:0] plus_final_time;
    logic [TIME_W-1:0] plus_switch_time;
    logic              minus_valid;
    logic [TIME_W-1:0] minus_final_time;
    logic [TIME_W-1:0] minus_switch_time;
  } out_word_t;

  typedef struct packed {
    logic                    vld;
    logic                    plus_ok;
    logic                    minus_ok;
    logic signed [VAL_W-1:0] vel;
  } ctl_t;

  typedef struct packed {
    logic vld;
    logic plus_ok;
    logic minus_ok;
  } flag_t;

endpackage

// ===== hdl/bbmti_isqrt.sv =====
module bbmti_isqrt import bbmti_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [S_W-1:0]    s_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  // One root bit per stage, most significant first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  test;
    logic [ROOT_W-1:0] root_in;

    if (k == 0) begin : g_first
      assign rem_in  = REM_W'(s_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign test = (REM_W'(root_in) << (B + 1)) | (REM_W'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= test) begin
          rem_q[k]  <= rem_in - test;
          root_q[k] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

// ===== hdl/bbmti_div.sv =====
module bbmti_div import bbmti_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [TIME_W-1:0] den_i,
  output logic [TIME_W-1:0] quo_o
);

  localparam int HI_W  = DVD_W - TIME_W;
  localparam int CMP_W = HI_W + TIME_W;

  logic [DVD_W-1:0]  dvd;
  logic [HI_W-1:0]   dvd_hi;
  logic [TIME_W:0]   rem_q [DIV_LAT];
  logic [TIME_W-1:0] lo_q  [DIV_LAT];
  logic [TIME_W-1:0] quo_q [DIV_LAT];
  logic              sat_q [DIV_LAT];

  assign dvd    = {num_i, {FRAC_BITS{1'b0}}};
  assign dvd_hi = dvd[DVD_W-1:TIME_W];

  // Flag overflow up front: the quotient fits only if the high part is below den
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0] <= CMP_W'(dvd_hi) >= CMP_W'(den_i);
      rem_q[0] <= (TIME_W + 1)'(dvd_hi);
      lo_q[0]  <= dvd[TIME_W-1:0];
      quo_q[0] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 1; j < DIV_LAT; j++) begin : g_stage
    localparam int BIT = TIME_W - j;
    logic [TIME_W:0] shifted;

    assign shifted = {rem_q[j-1][TIME_W-1:0], lo_q[j-1][BIT]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sat_q[j] <= sat_q[j-1];
        lo_q[j]  <= lo_q[j-1];
        if (shifted >= {1'b0, den_i}) begin
          rem_q[j] <= shifted - {1'b0, den_i};
          quo_q[j] <= quo_q[j-1] | (TIME_W'(1) << BIT);
        end else begin
          rem_q[j] <= shifted;
          quo_q[j] <= quo_q[j-1];
        end
      end
    end
  end

  assign quo_o = sat_q[DIV_LAT-1] ? '1 : quo_q[DIV_LAT-1];

endmodule

// ===== hdl/bang_bang_min_time_intercept.sv =====
// Minimum-time bang-bang intercept for a double integrator, Q16.16 fixed point.
// Each input word (start position, start velocity, target position) yields one
// result word with arrival and switch times for the +u_max-first and the
// -u_max-first profiles, each with its own valid flag; an invalid profile reports
// zero times and overlong times saturate at all ones. The block takes one word
// per clock and holds no state between words. The pipeline has three
// front stages (operand capture, the 32x32 and 31x33 products, the discriminant),
// 36 square root stages that settle one root bit each, one root selection stage,
// 33 divider stages (an overflow check, then one quotient bit each) and the output
// register. The whole pipeline advances together; it halts only while a result
// waits at the output and the receiver stalls. accel_limit sits at byte address
// 0 of the register port and must only be changed while no word is in flight.
module bang_bang_min_time_intercept import bbmti_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  output logic [APB_W-1:0]  prdata,
  output logic              pready
);

  // Register port: single register, always ready
  logic [ACC_W-1:0] accel_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACCEL_LIMIT) ? APB_W'(accel_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= ACCEL_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACCEL_LIMIT)) begin
      accel_q <= pwdata[ACC_W-1:0];
    end
  end

  // Advance everything unless the output word is held by the receiver
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage 1: capture velocity and position difference
  logic                     s1_vld_q;
  logic signed [DIFF_W-1:0] s1_diff_q;
  logic signed [VAL_W-1:0]  s1_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_diff_q <= DIFF_W'(in_word_i.start_pos) - DIFF_W'(in_word_i.target_pos);
      s1_vel_q  <= in_word_i.start_vel;
    end
  end

  // Stage 2: vel^2 and u*|diff|; the product u*|p| is the same for both signs
  logic                     s2_vld_q;
  logic signed [VAL_W-1:0]  s2_vel_q;
  logic [PROD_W-1:0]        s2_vv_q;
  logic [PROD_W-1:0]        s2_m_q;
  logic                     s2_pos_q;
  logic                     s2_neg_q;
  logic [DIFF_W-1:0]        s1_mag;
  logic signed [PROD_W-1:0] s1_vv;

  assign s1_mag = s1_diff_q[DIFF_W-1] ? DIFF_W'(-s1_diff_q) : DIFF_W'(s1_diff_q);
  assign s1_vv  = PROD_W'(s1_vel_q) * PROD_W'(s1_vel_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_vel_q <= s1_vel_q;
      s2_vv_q  <= PROD_W'(s1_vv);
      s2_m_q   <= PROD_W'(accel_q) * PROD_W'(s1_mag);
      s2_pos_q <= !s1_diff_q[DIFF_W-1] && (s1_diff_q != '0);
      s2_neg_q <= s1_diff_q[DIFF_W-1];
    end
  end

  // Stage 3: discriminant S = 2v^2 - 4*s*u*d for each sign
  logic [S_W-1:0] a_ext;
  logic [S_W-1:0] m4_ext;
  logic [S_W-1:0] s_add;
  logic [S_W-1:0] s_sub;
  logic           sub_ok;
  logic           u_nz;
  ctl_t           s3_ctl_q;
  logic [S_W-1:0] s3_plus_q;
  logic [S_W-1:0] s3_minus_q;

  assign a_ext  = S_W'(s2_vv_q) << 1;
  assign m4_ext = S_W'(s2_m_q) << 2;
  assign s_add  = m4_ext + a_ext;
  assign s_sub  = a_ext - m4_ext;
  assign sub_ok = m4_ext <= a_ext;
  assign u_nz   = accel_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctl_q <= '0;
    end else if (en) begin
      s3_ctl_q.vld      <= s2_vld_q;
      s3_ctl_q.plus_ok  <= u_nz && (!s2_pos_q || sub_ok);
      s3_ctl_q.minus_ok <= u_nz && (!s2_neg_q || sub_ok);
      s3_ctl_q.vel      <= s2_vel_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_plus_q  <= s2_pos_q ? s_sub : s_add;
      s3_minus_q <= s2_neg_q ? s_sub : s_add;
    end
  end

  // Square roots, with control delayed alongside
  logic [ROOT_W-1:0] root_plus;
  logic [ROOT_W-1:0] root_minus;
  ctl_t              sq_ctl_q [SQRT_LAT];

  bbmti_isqrt u_sqrt_plus (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s3_plus_q),
    .root_o (root_plus)
  );

  bbmti_isqrt u_sqrt_minus (
    .clk_i  (clk_i),
    .en_i   (en),
    .s_i    (s3_minus_q),
    .root_o (root_minus)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SQRT_LAT; i++) sq_ctl_q[i] <= '0;
    end else if (en) begin
      sq_ctl_q[0] <= s3_ctl_q;
      for (int i = 1; i < SQRT_LAT; i++) sq_ctl_q[i] <= sq_ctl_q[i-1];
    end
  end

  // Root selection: try the +sqrt numerator, then the -sqrt one, against |v|
  localparam int N_W = NUM_W + 1;

  typedef struct packed {
    logic             found;
    logic [NUM_W-1:0] num_tf;
    logic [NUM_W-1:0] num_ts;
  } pick_t;

  function automatic pick_t pick_root(input logic neg, input logic [ROOT_W-1:0] root,
                                      input logic signed [VAL_W-1:0] vel);
    logic signed [N_W-1:0] rs;
    logic signed [N_W-1:0] vs;
    logic signed [N_W-1:0] absv;
    logic signed [N_W-1:0] n1;
    logic signed [N_W-1:0] n2;
    logic signed [N_W-1:0] n;
    logic signed [N_W-1:0] nts;
    pick_t                 res;
    rs   = signed'(N_W'(root));
    vs   = N_W'(vel);
    absv = vs[N_W-1] ? -vs : vs;
    n1   = neg ? (vs - rs) : (rs - vs);
    n2   = neg ? (rs + vs) : -(rs + vs);
    res.found = 1'b1;
    if (n1 >= absv) begin
      n = n1;
    end else if (n2 >= absv) begin
      n = n2;
    end else begin
      n = '0;
      res.found = 1'b0;
    end
    nts = neg ? (n + vs) : (n - vs);
    res.num_tf = n[NUM_W-1:0];
    res.num_ts = nts[NUM_W-1:0];
    return res;
  endfunction

  pick_t pk_plus;
  pick_t pk_minus;
  flag_t po_flag_q;
  pick_t po_plus_q;
  pick_t po_minus_q;

  assign pk_plus  = pick_root(1'b0, root_plus, sq_ctl_q[SQRT_LAT-1].vel);
  assign pk_minus = pick_root(1'b1, root_minus, sq_ctl_q[SQRT_LAT-1].vel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      po_flag_q <= '0;
    end else if (en) begin
      po_flag_q.vld      <= sq_ctl_q[SQRT_LAT-1].vld;
      po_flag_q.plus_ok  <= sq_ctl_q[SQRT_LAT-1].plus_ok && pk_plus.found;
      po_flag_q.minus_ok <= sq_ctl_q[SQRT_LAT-1].minus_ok && pk_minus.found;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      po_plus_q  <= pk_plus;
      po_minus_q <= pk_minus;
    end
  end

  // Four dividers: times over u and switch times over 2u
  logic [TIME_W-1:0] den_tf;
  logic [TIME_W-1:0] den_ts;
  logic [TIME_W-1:0] tf_plus;
  logic [TIME_W-1:0] ts_plus;
  logic [TIME_W-1:0] tf_minus;
  logic [TIME_W-1:0] ts_minus;
  flag_t             dv_flag_q [DIV_LAT];

  assign den_tf = TIME_W'(accel_q);
  assign den_ts = {accel_q, 1'b0};

  bbmti_div u_div_tf_plus (
    .clk_i (clk_i), .en_i (en), .num_i (po_plus_q.num_tf),  .den_i (den_tf), .quo_o (tf_plus)
  );

  bbmti_div u_div_ts_plus (
    .clk_i (clk_i), .en_i (en), .num_i (po_plus_q.num_ts),  .den_i (den_ts), .quo_o (ts_plus)
  );

  bbmti_div u_div_tf_minus (
    .clk_i (clk_i), .en_i (en), .num_i (po_minus_q.num_tf), .den_i (den_tf), .quo_o (tf_minus)
  );

  bbmti_div u_div_ts_minus (
    .clk_i (clk_i), .en_i (en), .num_i (po_minus_q.num_ts), .den_i (den_ts), .quo_o (ts_minus)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) dv_flag_q[i] <= '0;
    end else if (en) begin
      dv_flag_q[0] <= po_flag_q;
      for (int i = 1; i < DIV_LAT; i++) dv_flag_q[i] <= dv_flag_q[i-1];
    end
  end

  // Output register: drop the times of an invalid profile to zero
  out_word_t out_word_q;
  flag_t     last_flag;

  assign last_flag = dv_flag_q[DIV_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last_flag.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_q.plus_valid        <= last_flag.plus_ok;
      out_word_q.plus_final_time   <= last_flag.plus_ok ? tf_plus : '0;
      out_word_q.plus_switch_time  <= last_flag.plus_ok ? ts_plus : '0;
      out_word_q.minus_valid       <= last_flag.minus_ok;
      out_word_q.minus_final_time  <= last_flag.minus_ok ? tf_minus : '0;
      out_word_q.minus_switch_time <= last_flag.minus_ok ? ts_minus : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Checks
  a_plus_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.plus_valid |->
      out_word_o.plus_final_time == '0 && out_word_o.plus_switch_time == '0)
    else $error("invalid plus profile carries nonzero time");

  a_minus_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.minus_valid |->
      out_word_o.minus_switch_time <= out_word_o.minus_final_time)
    else $error("minus switch time after arrival");

  a_plus_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.plus_valid |->
      out_word_o.plus_switch_time <= out_word_o.plus_final_time)
    else $error("plus switch time after arrival");

  a_zero_accel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accel_q == '0 |-> !out_word_o.plus_valid && !out_word_o.minus_valid)
    else $error("profile valid with zero acceleration limit");

endmodule

// ===== verif/bbmti_checker.sv =====
`timescale 1ns / 1ps

module bbmti_checker import bbmti_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_word_t          in_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_word_t         out_word_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  input  logic              pready,
  output int                fail_count_o,
  output int                pending_o
);

  localparam logic [ADDR_W-1:0] ACCEL_ADDR = ADDR_W'({REG_ACCEL_LIMIT, 2'b00});

  logic [ACC_W-1:0] accel_q;
  out_word_t        intercept_q[$];
  int               fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = intercept_q.size();

  // Solve one profile; s is the sign of the first acceleration.
  function automatic void solve_profile(input int s, input longint v, input longint d,
                                        input logic [ACC_W-1:0] u, output logic ok,
                                        output logic [TIME_W-1:0] tf,
                                        output logic [TIME_W-1:0] ts);
    logic signed [95:0] vv, dd, uu, ss, disc, cand, rr, n1, n2, n, absv, q;
    logic [35:0] r;
    ok = 1'b0;
    tf = '0;
    ts = '0;
    vv = 96'(v);
    dd = 96'(d);
    ss = 96'(s);
    uu = $signed({65'b0, u});
    if (u == '0) return;
    disc = 2 * vv * vv - 4 * ss * uu * dd;
    if (disc < 0) return;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      cand = $signed({60'b0, r | (36'd1 << b)});
      if (cand * cand <= disc) r = r | (36'd1 << b);
    end
    rr = $signed({60'b0, r});
    absv = vv < 0 ? -vv : vv;
    n1 = ss * (rr - vv);
    n2 = -ss * (rr + vv);
    if (n1 >= absv) n = n1;
    else if (n2 >= absv) n = n2;
    else return;
    ok = 1'b1;
    q = (n <<< FRAC_BITS) / uu;
    tf = (q > 96'sh0FFFFFFFF) ? '1 : q[TIME_W-1:0];
    q = ((n - ss * vv) <<< FRAC_BITS) / (2 * uu);
    ts = (q > 96'sh0FFFFFFFF) ? '1 : q[TIME_W-1:0];
  endfunction

  function automatic out_word_t predict_intercept(input in_word_t w, input logic [ACC_W-1:0] u);
    out_word_t r;
    longint v, d;
    v = longint'(w.start_vel);
    d = longint'(w.start_pos) - longint'(w.target_pos);
    solve_profile(1, v, d, u, r.plus_valid, r.plus_final_time, r.plus_switch_time);
    solve_profile(-1, v, d, u, r.minus_valid, r.minus_final_time, r.minus_switch_time);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                             input logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= ACCEL_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ACCEL_ADDR) begin
      accel_q <= pwdata[ACC_W-1:0];
    end
  end

  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (intercept_q.size() == 0) begin
          $display("%0t unexpected word: expected none actual %h", $time, out_word_i);
          fails++;
        end else begin
          e = intercept_q.pop_front();
          check_field("plus_valid", TIME_W'(e.plus_valid), TIME_W'(out_word_i.plus_valid));
          check_field("plus_final_time", e.plus_final_time, out_word_i.plus_final_time);
          check_field("plus_switch_time", e.plus_switch_time, out_word_i.plus_switch_time);
          check_field("minus_valid", TIME_W'(e.minus_valid),
                      TIME_W'(out_word_i.minus_valid));
          check_field("minus_final_time", e.minus_final_time, out_word_i.minus_final_time);
          check_field("minus_switch_time", e.minus_switch_time,
                      out_word_i.minus_switch_time);
        end
      end
      // Append the prediction at the tail of the expected queue
      if (in_valid_i && !in_stall_i)
        intercept_q = {intercept_q, predict_intercept(in_word_i, accel_q)};
    end
  end

endmodule

// ===== verif/bang_bang_min_time_intercept_tb.sv =====
`timescale 1ns / 1ps

module bang_bang_min_time_intercept_tb;
  import bbmti_pkg::*;

  // Pipeline is 74 deep; leave margin for the drain wait.
  localparam int DRAIN_CYCLES = 100;
  localparam int WATCHDOG_MAX = 5000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_word;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_word;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;
  int                fail_count, pending;
  bit                quiet;   // no idling on either side
  int                idle_cycles;

  bang_bang_min_time_intercept dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  bbmti_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_word_i(in_word),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_word_i(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: stall in random bursts, change only on the falling edge.
  initial begin
    int burst;
    out_stall = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles in which no word and no register write is accepted.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("%0t watchdog expired, %0d words outstanding", $time, pending);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Write the acceleration limit: setup cycle, then access cycle until pready.
  task automatic write_accel(input logic [APB_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({REG_ACCEL_LIMIT, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one word; an idle burst may come first. Hold it until accepted.
  task automatic send_word(input in_word_t w);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait for every result, then let the pipeline empty out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 6))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return VAL_W'($urandom_range(0, 2 ** 20)) - 32'd524288;
      3: return VAL_W'($urandom_range(0, 255)) << 16;
      4: return -(VAL_W'($urandom_range(0, 255)) << 16);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(input int count);
    in_word_t w;
    repeat (count) begin
      w.start_pos  = pick_value();
      w.start_vel  = pick_value();
      // Often aim near the start so both profiles have a chance.
      w.target_pos = ($urandom_range(0, 2) == 0) ? w.start_pos + pick_value() / 256
                                                  : pick_value();
      send_word(w);
    end
  endtask

  task automatic send_directed();
    logic [VAL_W-1:0] ext[5];
    in_word_t w;
    ext = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h00010000, 32'hFFFF0000};
    for (int i = 0; i < 5; i++) begin
      w.start_pos  = ext[i];
      w.start_vel  = ext[(i + 1) % 5];
      w.target_pos = ext[(i + 3) % 5];
      send_word(w);
      w.start_pos  = ext[i];
      w.start_vel  = ext[i];
      w.target_pos = ~ext[i];
      send_word(w);
    end
    // Already at the target at rest, and at the target while moving.
    w = '0;
    send_word(w);
    w.start_vel = 32'h00030000;
    send_word(w);
    w.start_vel = -32'sh00030000;
    send_word(w);
    // Target far ahead while moving away: long times saturate.
    w.start_pos = 32'h80000000;
    w.start_vel = 32'h80000000;
    w.target_pos = 32'h7FFFFFFF;
    send_word(w);
    // Target just behind while moving fast away from it.
    w.start_pos = 32'h00000000;
    w.start_vel = 32'h7FFFFFFF;
    w.target_pos = 32'hFFFFFF00;
    send_word(w);
  endtask

  initial begin
    in_valid = 1'b0;
    in_word  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    quiet    = 1'b0;
    rst_n    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset value first, directed words, then sweep the limit.
    send_directed();
    send_random(60);
    drain();
    write_accel(32'd65536);
    send_random(40);
    // Hold off the sender until every result is back, then resume.
    drain();
    send_random(40);
    drain();
    write_accel(32'd1);
    send_directed();
    send_random(60);
    drain();
    write_accel(32'h7FFFFFFF);
    send_directed();
    send_random(60);
    drain();
    write_accel(32'd0);
    send_random(30);
    drain();
    write_accel(32'hFFFFFFFF);
    send_random(30);
    drain();
    write_accel($urandom() | 32'd1);
    send_random(80);
    drain();
    write_accel(32'd131072);
    quiet = 1'b1;
    send_random(80);
    drain();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
